[rtl/drc_pkg.sv]
// Types and constants shared by the differential render composite block.
// Used by drc_front, drc_cell and differential_render_composite.
package drc_pkg;

	localparam int unsigned NumCh = 3;
	localparam int unsigned PixW  = 8;
	localparam int unsigned QuoW  = 8;
	localparam int unsigned RemW  = 16;
	localparam logic [PixW-1:0] PixMax = 8'hFF;

	typedef struct packed {
		logic [PixW-1:0] scene_r;
		logic [PixW-1:0] scene_g;
		logic [PixW-1:0] scene_b;
		logic [PixW-1:0] local_r;
		logic [PixW-1:0] local_g;
		logic [PixW-1:0] local_b;
		logic [PixW-1:0] geom_r;
		logic [PixW-1:0] geom_g;
		logic [PixW-1:0] geom_b;
		logic [PixW-1:0] geom_weight;
		logic [PixW-1:0] local_weight;
	} pix_in_t;

	typedef struct packed {
		logic [PixW-1:0] out_r;
		logic [PixW-1:0] out_g;
		logic [PixW-1:0] out_b;
	} pix_out_t;

	// One channel after the multiplier front end
	typedef struct packed {
		logic [RemW-1:0] p;     // floor(L*(256-G)*scene*geom / 65536)
		logic [PixW-1:0] t1;
		logic [PixW-1:0] t2;
		logic [PixW-1:0] lcl;
		logic            gnz;   // geom channel is nonzero
	} front_ch_t;

	typedef front_ch_t [NumCh-1:0] front_t;

	// One channel as it moves along the divider cells
	typedef struct packed {
		logic [RemW-1:0] rem;
		logic [PixW-1:0] dvs;
		logic [QuoW-1:0] quo;
		logic [PixW:0]   base;  // t1 + t2
		logic            sat;   // third term reaches 256 or more
	} ch_work_t;

	typedef ch_work_t [NumCh-1:0] work_t;

endpackage

[rtl/drc_front.sv]
// Two-stage multiplier front end: forms t1, t2 and the scaled numerator of t3.
// Depends on drc_pkg.
module drc_front import drc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    up_valid,
	output logic    up_ready,
	input  pix_in_t up_pix,
	output logic    dn_valid,
	input  logic    dn_ready,
	output front_t  dn_front
);

	logic [NumCh-1:0][PixW-1:0] s, l, g;
	logic [PixW:0]              ngw, nlw;
	logic [2*PixW+1:0]          b_full;
	logic [2*PixW:0]            c_full;

	// stage 1 registers
	logic                         v_s1;
	logic [NumCh-1:0][2*PixW-1:0] a_s1, e_s1;
	logic [NumCh-1:0][PixW-1:0]   s_s1, l_s1;
	logic [NumCh-1:0]             gnz_s1;
	logic [2*PixW:0]              b_s1;
	logic [2*PixW-1:0]            c_s1;

	// stage 2
	logic                         v_s2;
	logic                         rdy_s1, rdy_s2;
	logic [NumCh-1:0][3*PixW:0]   t2_full;
	logic [NumCh-1:0][4*PixW-1:0] num;
	front_t                       front_s2;

	always_comb begin
		s[0] = up_pix.scene_r;
		s[1] = up_pix.scene_g;
		s[2] = up_pix.scene_b;
		l[0] = up_pix.local_r;
		l[1] = up_pix.local_g;
		l[2] = up_pix.local_b;
		g[0] = up_pix.geom_r;
		g[1] = up_pix.geom_g;
		g[2] = up_pix.geom_b;
		ngw = 9'd256 - {1'b0, up_pix.geom_weight};
		nlw = 9'd256 - {1'b0, up_pix.local_weight};
		b_full = ngw * nlw;
		c_full = ngw * {1'b0, up_pix.local_weight};
	end

	assign rdy_s2   = !v_s2 || dn_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= up_valid;
			if (rdy_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			for (int ch = 0; ch < NumCh; ch++) begin
				a_s1[ch]   <= up_pix.geom_weight * g[ch];
				e_s1[ch]   <= s[ch] * g[ch];
				s_s1[ch]   <= s[ch];
				l_s1[ch]   <= l[ch];
				gnz_s1[ch] <= (g[ch] != '0);
			end
			b_s1 <= b_full[2*PixW:0];
			c_s1 <= c_full[2*PixW-1:0];
		end
	end

	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			t2_full[ch] = b_s1 * s_s1[ch];
			num[ch]     = c_s1 * e_s1[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			for (int ch = 0; ch < NumCh; ch++) begin
				front_s2[ch].p   <= num[ch][4*PixW-1:2*PixW];
				front_s2[ch].t1  <= a_s1[ch][2*PixW-1:PixW];
				front_s2[ch].t2  <= t2_full[ch][3*PixW-1:2*PixW];
				front_s2[ch].lcl <= l_s1[ch];
				front_s2[ch].gnz <= gnz_s1[ch];
			end
		end
	end

	assign dn_valid = v_s2;
	assign dn_front = front_s2;

endmodule

[rtl/drc_cell.sv]
// One restoring division cell: settles one quotient bit for all three channels.
// Depends on drc_pkg.
module drc_cell import drc_pkg::*; #(
	parameter int unsigned BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  work_t up_work,
	output logic  dn_valid,
	input  logic  dn_ready,
	output work_t dn_work
);

	logic                      valid_q;
	work_t                     work_q;
	work_t                     nxt;
	logic [NumCh-1:0][RemW-1:0] sh;

	always_comb begin
		nxt = up_work;
		for (int ch = 0; ch < NumCh; ch++) begin
			sh[ch] = RemW'(up_work[ch].dvs) << BIT;
			// hold the quotient at zero for a zero local channel
			if ((up_work[ch].dvs != '0) && (up_work[ch].rem >= sh[ch])) begin
				nxt[ch].rem      = up_work[ch].rem - sh[ch];
				nxt[ch].quo[BIT] = 1'b1;
			end
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid)
			work_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn_work  = work_q;

endmodule

[rtl/differential_render_composite.sv]
// Pipeline: 2 multiplier stages, 8 division cells and 1 output register.
// Throughput: one item per cycle while result_stall is low; the chain of
// division cells, one quotient bit each, sets the depth.
// Reset (arst_n low, asynchronous) empties every stage; no state is kept.
// Top level of the differential render composite; depends on drc_pkg,
// drc_front and drc_cell.
module differential_render_composite import drc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pixel_valid,
	output logic     pixel_stall,
	input  pix_in_t  pixel,
	output logic     result_valid,
	input  logic     result_stall,
	output pix_out_t result
);

	logic        front_valid, front_ready, pixel_ready;
	front_t      front;
	logic        v [QuoW+1];
	logic        r [QuoW+1];
	work_t       w [QuoW+1];

	logic        res_valid_q;
	pix_out_t    res_q;
	logic [PixW-1:0]            ch_out [NumCh];
	logic [NumCh-1:0][PixW+1:0] sum;

	drc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pixel_valid),
		.up_ready (pixel_ready),
		.up_pix   (pixel),
		.dn_valid (front_valid),
		.dn_ready (front_ready),
		.dn_front (front)
	);

	assign pixel_stall = !pixel_ready;

	// Seed the divider: t3 = floor(p / local); flag it when it cannot fit 8 bits
	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			w[0][ch].rem  = front[ch].p;
			w[0][ch].dvs  = front[ch].lcl;
			w[0][ch].quo  = '0;
			w[0][ch].base = {1'b0, front[ch].t1} + {1'b0, front[ch].t2};
			if (front[ch].lcl == '0)
				w[0][ch].sat = front[ch].gnz;
			else
				w[0][ch].sat = (front[ch].p[RemW-1:QuoW] >= front[ch].lcl);
		end
	end

	assign v[0]        = front_valid;
	assign front_ready = r[0];

	for (genvar k = 0; k < QuoW; k++) begin : g_cell
		drc_cell #(
			.BIT (QuoW - 1 - k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v[k]),
			.up_ready (r[k]),
			.up_work  (w[k]),
			.dn_valid (v[k+1]),
			.dn_ready (r[k+1]),
			.dn_work  (w[k+1])
		);
	end

	assign r[QuoW] = !res_valid_q || !result_stall;

	// Add the three terms and clamp
	always_comb begin
		for (int ch = 0; ch < NumCh; ch++) begin
			sum[ch] = {1'b0, w[QuoW][ch].base} + {2'b00, w[QuoW][ch].quo};
			if (w[QuoW][ch].sat || (sum[ch] > {2'b00, PixMax}))
				ch_out[ch] = PixMax;
			else
				ch_out[ch] = sum[ch][PixW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (r[QuoW]) begin
			res_valid_q <= v[QuoW];
		end
	end

	always_ff @(posedge clk) begin
		if (r[QuoW] && v[QuoW]) begin
			res_q.out_r <= ch_out[0];
			res_q.out_g <= ch_out[1];
			res_q.out_b <= ch_out[2];
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTH
	// The front end only stalls when every stage is full behind a stalled result
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> (result_valid && result_stall))
		else $error("input stalled while the pipeline has room");

	// Unsaturated channels enter the divider with a quotient that fits 8 bits
	a_seed_fits: assert property (@(posedge clk) disable iff (!arst_n)
		v[0] |->
			(w[0][0].sat || w[0][0].dvs == '0 || w[0][0].rem < {w[0][0].dvs, 8'h00}) &&
			(w[0][1].sat || w[0][1].dvs == '0 || w[0][1].rem < {w[0][1].dvs, 8'h00}) &&
			(w[0][2].sat || w[0][2].dvs == '0 || w[0][2].rem < {w[0][2].dvs, 8'h00}))
		else $error("divider seeded with an oversized quotient");

	// After the last cell the remainder is below the divisor
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		v[QuoW] |->
			(w[QuoW][0].sat || w[QuoW][0].dvs == '0 || w[QuoW][0].rem < 16'(w[QuoW][0].dvs)) &&
			(w[QuoW][1].sat || w[QuoW][1].dvs == '0 || w[QuoW][1].rem < 16'(w[QuoW][1].dvs)) &&
			(w[QuoW][2].sat || w[QuoW][2].dvs == '0 || w[QuoW][2].rem < 16'(w[QuoW][2].dvs)))
		else $error("division left a remainder not below the divisor");
`endif

endmodule
